>>> src/memory_leak_trend_check_defines.svh
// ----------------------------------------------------------------------------
// memory leak trend check assertion macros
// shared property forms for the rtl checks of the block
// ----------------------------------------------------------------------------
`ifndef MEMORY_LEAK_TREND_CHECK_DEFINES_SVH
`define MEMORY_LEAK_TREND_CHECK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LKTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lktc check failed");

// next-cycle implication, checked out of reset
`define LKTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lktc check failed");

`endif

>>> src/lktc_pkg.sv
// ----------------------------------------------------------------------------
// lktc_pkg
// word types and constants of the memory leak trend check
// ----------------------------------------------------------------------------
package lktc_pkg;

  localparam int SAMPLE_W    = 31;
  localparam int LIMIT_W     = 21;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_IDX_W   = 1;
  localparam int GAP_SHIFT   = 10;
  localparam int MIN_SAMPLES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST = 21'd100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_pss;
    logic                last_sample;
  } in_word_t;

  typedef struct packed {
    logic enough_samples;
    logic gap_exceeded;
    logic trend_found;
    logic leak_report;
    logic history_overflow;
  } out_word_t;

endpackage

>>> src/memory_leak_trend_check.sv
// ----------------------------------------------------------------------------
// memory_leak_trend_check
// collects usage samples, newest first, and on the oldest one reports gap,
// trend and leak flags from a pairwise scan of the stored history
// ----------------------------------------------------------------------------
// usage
//   in_word carries one sample per word; last_sample marks the oldest one.
//   a word is taken when in_valid is high and in_stall low. samples beyond
//   DEPTH are dropped and flagged as history overflow.
//   the word with last_sample starts an evaluation; in_stall stays high until
//   the result is loaded into the output register. other words do not stall.
//   with n kept samples (n >= 5) a pairwise scan runs; with n <= 4 the
//   result is formed directly without a scan. the single memory read port
//   limits the scan to one pair compared per cycle.
//   out_word is held while out_stall is high; new samples are still taken
//   while a finished result waits, the next evaluation waits for the slot.
//   cfg_wr_en writes baseline_pss (index 0) or gap_limit_mib (index 1);
//   write only while the block is idle.
//   reset (rst_n low, synchronous) empties the history, drops any pending
//   result and sets baseline 0 and gap limit 100.
// ----------------------------------------------------------------------------
`include "memory_leak_trend_check_defines.svh"

module memory_leak_trend_check import lktc_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDJ  = 3'd1;
  localparam logic [2:0] ST_LDJ  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic                ovf_res_r, ovf_res_nxt;
  logic [ADDR_W-1:0]   j_r, j_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]    below_r, below_nxt;
  logic [CNT_W-1:0]    marked_r, marked_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;
  logic [SAMPLE_W-1:0] baseline_r, baseline_nxt;
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [SAMPLE_W-1:0] newest_r, newest_nxt;
  logic [SAMPLE_W-1:0] sj_r, sj_nxt;

  logic                in_acc;
  logic                wr_en;
  logic [CNT_W-1:0]    cnt_after;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [CNT_W-1:0]    older;
  logic [CNT_W-1:0]    ratio_a, ratio_b;
  logic                ratio_ge;
  logic [SAMPLE_W:0]   diff;
  logic                gap;
  logic                enough;
  logic                trend;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign wr_en     = in_acc && (cnt_r != CNT_W'(DEPTH));
  assign cnt_after = wr_en ? cnt_r + CNT_W'(1) : cnt_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  lktc_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_word.sample_pss),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    case (state_r)
      ST_RDJ:  rd_addr = j_r;
      ST_LDJ:  rd_addr = j_r + ADDR_W'(1);
      default: rd_addr = k_r + ADDR_W'(1);
    endcase
  end

  // shared ratio unit: per-sample mark, then the final trend test
  assign older   = total_r - CNT_W'(j_r) - CNT_W'(1);
  assign ratio_a = (state_r == ST_MARK) ? below_r : marked_r;
  assign ratio_b = (state_r == ST_MARK) ? older : total_r;

  lktc_ratio #(
    .W (CNT_W)
  ) u_ratio (
    .a  (ratio_a),
    .b  (ratio_b),
    .ge (ratio_ge)
  );

  // gap: positive difference shifted down by the 1024 unit
  assign diff   = {1'b0, newest_r} - {1'b0, baseline_r};
  assign enough = (total_r >= CNT_W'(MIN_SAMPLES));
  assign gap    = enough && !diff[SAMPLE_W]
                  && (diff[SAMPLE_W-1:GAP_SHIFT] > limit_r);
  assign trend  = enough && ratio_ge;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    ovf_res_nxt   = ovf_res_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    below_nxt     = below_r;
    marked_nxt    = marked_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    baseline_nxt  = baseline_r;
    limit_nxt     = limit_r;
    newest_nxt    = newest_r;
    sj_nxt        = sj_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_BASELINE:  baseline_nxt = cfg_wr_data[SAMPLE_W-1:0];
        REG_GAP_LIMIT: limit_nxt    = cfg_wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r == '0) begin
            newest_nxt = in_word.sample_pss;
          end
          ovf_nxt = ovf_r || !wr_en;
          cnt_nxt = cnt_after;
          if (in_word.last_sample) begin
            total_nxt   = cnt_after;
            ovf_res_nxt = ovf_r || !wr_en;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            j_nxt       = '0;
            marked_nxt  = '0;
            state_nxt   = (cnt_after > CNT_W'(MIN_SAMPLES)) ? ST_RDJ : ST_FIN;
          end
        end
      end
      ST_RDJ: begin
        state_nxt = ST_LDJ;
      end
      ST_LDJ: begin
        sj_nxt    = rd_data;
        below_nxt = '0;
        k_nxt     = j_r + ADDR_W'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        below_nxt = below_r + CNT_W'(sj_r > rd_data);
        if (CNT_W'(k_r) + CNT_W'(1) == total_r) begin
          state_nxt = ST_MARK;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end
      ST_MARK: begin
        marked_nxt = marked_r + CNT_W'(ratio_ge);
        j_nxt      = j_r + ADDR_W'(1);
        if (CNT_W'(j_r) + CNT_W'(MIN_SAMPLES + 1) < total_r) begin
          state_nxt = ST_RDJ;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt.enough_samples   = enough;
          out_word_nxt.gap_exceeded     = gap;
          out_word_nxt.trend_found      = trend;
          out_word_nxt.leak_report      = trend && !gap;
          out_word_nxt.history_overflow = ovf_res_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      baseline_r  <= '0;
      limit_r     <= GAP_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      baseline_r  <= baseline_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    ovf_res_r  <= ovf_res_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    below_r    <= below_nxt;
    marked_r   <= marked_nxt;
    out_word_r <= out_word_nxt;
    newest_r   <= newest_nxt;
    sj_r       <= sj_nxt;
  end

  `LKTC_ASSERT_IMP(a_scan_past_pivot, clk, rst_n, state_r == ST_SCAN, k_r > j_r)
  `LKTC_ASSERT_IMP(a_cnt_in_range, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `LKTC_ASSERT_IMP(a_marked_bounded, clk, rst_n, state_r == ST_FIN, marked_r <= total_r)
  `LKTC_ASSERT_NXT(a_last_empties, clk, rst_n, in_acc && in_word.last_sample, cnt_r == '0)

endmodule

>>> src/lktc_store.sv
// ----------------------------------------------------------------------------
// lktc_store
// sample history memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module lktc_store import lktc_pkg::*; #(
  parameter int  DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/lktc_ratio.sv
// ----------------------------------------------------------------------------
// lktc_ratio
// shared four-fifths test: 5*a >= 4*b
// ----------------------------------------------------------------------------
module lktc_ratio import lktc_pkg::*; #(
  parameter int W = 7
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge
);

  logic [W+2:0] a5;
  logic [W+2:0] b4;

  assign a5 = {1'b0, a, 2'b00} + {3'b000, a};
  assign b4 = {1'b0, b, 2'b00};
  assign ge = (a5 >= b4);

endmodule
